### hw/rtl/ocia_pkg.sv
// Shared types and opcode constants for the overflow-checked integer ALU.
// No dependencies.
package ocia_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned HalfW = DataW / 2;

    typedef logic [3:0]         opcode_t;
    typedef logic [DataW-1:0]   data_t;
    typedef logic [2*DataW-1:0] wide_t;

    localparam opcode_t OP_ADD_S32 = 4'd0;
    localparam opcode_t OP_ADD_U32 = 4'd1;
    localparam opcode_t OP_ADD_S64 = 4'd2;
    localparam opcode_t OP_ADD_U64 = 4'd3;
    localparam opcode_t OP_SUB_S32 = 4'd4;
    localparam opcode_t OP_SUB_S64 = 4'd5;
    localparam opcode_t OP_MUL_S32 = 4'd6;
    localparam opcode_t OP_MUL_U32 = 4'd7;
    localparam opcode_t OP_MUL_S64 = 4'd8;
    localparam opcode_t OP_MUL_U64 = 4'd9;

    // load enables for the multiplier stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

### hw/rtl/ocia_if.sv
// Valid/ready channels for request and response words.
// Depends on ocia_pkg.
interface ocia_req_if
    import ocia_pkg::*;
();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    data_t   operand_a;
    data_t   operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

interface ocia_rsp_if
    import ocia_pkg::*;
();
    logic  valid;
    logic  ready;
    data_t result_value;
    logic  overflowed;

    modport source (output valid, output result_value, output overflowed, input ready);
    modport sink   (input valid, input result_value, input overflowed, output ready);
endinterface

### hw/rtl/ocia_mul.sv
// Three-stage 64x64 unsigned multiplier from four 32x32 partial products,
// with the signed high-half correction term. Depends on ocia_pkg.
module ocia_mul
    import ocia_pkg::*;
(
    input  logic      clk,
    input  stage_en_t en,
    input  data_t     a,
    input  data_t     b,
    output wide_t     prod,
    output data_t     corr
);

    data_t              pp00_reg, pp10_reg, pp01_reg, pp11_reg;
    data_t              a_reg, b_reg;
    logic [DataW:0]     cross_reg;
    data_t              lo3_reg, hi3_reg, corr3_reg;
    wide_t              prod_reg;
    data_t              corr4_reg;

    data_t              pp00_next, pp10_next, pp01_next, pp11_next;
    logic [DataW:0]     cross_next;
    data_t              corr_next;
    wide_t              prod_next;

    always_comb
    begin
        pp00_next  = {{HalfW{1'b0}}, a[HalfW-1:0]}     * {{HalfW{1'b0}}, b[HalfW-1:0]};
        pp10_next  = {{HalfW{1'b0}}, a[DataW-1:HalfW]} * {{HalfW{1'b0}}, b[HalfW-1:0]};
        pp01_next  = {{HalfW{1'b0}}, a[HalfW-1:0]}     * {{HalfW{1'b0}}, b[DataW-1:HalfW]};
        pp11_next  = {{HalfW{1'b0}}, a[DataW-1:HalfW]} * {{HalfW{1'b0}}, b[DataW-1:HalfW]};
        cross_next = {1'b0, pp10_reg} + {1'b0, pp01_reg};
        corr_next  = (a_reg[DataW-1] ? b_reg : '0) + (b_reg[DataW-1] ? a_reg : '0);
        prod_next  = {hi3_reg, lo3_reg}
                   + {{(HalfW-1){1'b0}}, cross_reg, {HalfW{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            pp00_reg <= pp00_next;
            pp10_reg <= pp10_next;
            pp01_reg <= pp01_next;
            pp11_reg <= pp11_next;
            a_reg    <= a;
            b_reg    <= b;
        end
        if (en.s3)
        begin
            cross_reg <= cross_next;
            lo3_reg   <= pp00_reg;
            hi3_reg   <= pp11_reg;
            corr3_reg <= corr_next;
        end
        if (en.s4)
        begin
            prod_reg  <= prod_next;
            corr4_reg <= corr3_reg;
        end
    end

    assign prod = prod_reg;
    assign corr = corr4_reg;

endmodule

### hw/rtl/overflow_checked_int_alu_core.sv
// Overflow-checked integer ALU: add, subtract and multiply with overflow flag.
// One word per cycle sustained while response.ready is held high; a low ready stalls the flow.
// Rate is set by the five-stage pipeline around the 64x64 multiplier.
// Each stage stalls only when full and its successor cannot take its word.
// rst_n (async, active low) clears all valid bits; data registers are not reset.
// Depends on ocia_pkg, ocia_if, ocia_mul.
module overflow_checked_int_alu_core
    import ocia_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ocia_req_if.sink  request,
    ocia_rsp_if.source response
);

    logic      v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic      ld1, ld2, ld3, ld4, ldo;
    stage_en_t mul_en;

    opcode_t   op1_reg, op2_reg, op3_reg, op4_reg;
    data_t     a1_reg, b1_reg;
    data_t     res2_reg, res3_reg, res4_reg;
    logic      ovf2_reg, ovf3_reg, ovf4_reg;
    data_t     res_o_reg;
    logic      ovf_o_reg;

    data_t     a1_next, b1_next;
    data_t     res2_next;
    logic      ovf2_next;
    data_t     res_o_next;
    logic      ovf_o_next;

    wide_t     prod;
    data_t     corr;

    // stall chain
    assign ldo = !vo_reg || response.ready;
    assign ld4 = !v4_reg || ldo;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign request.ready = ld1;

    assign mul_en.s2 = ld2;
    assign mul_en.s3 = ld3;
    assign mul_en.s4 = ld4;

    // operand extension for 32-bit ops
    always_comb
    begin
        a1_next = request.operand_a;
        b1_next = request.operand_b;
        if (request.opcode == OP_ADD_S32 || request.opcode == OP_SUB_S32 ||
            request.opcode == OP_MUL_S32)
        begin
            a1_next = {{HalfW{request.operand_a[HalfW-1]}}, request.operand_a[HalfW-1:0]};
            b1_next = {{HalfW{request.operand_b[HalfW-1]}}, request.operand_b[HalfW-1:0]};
        end
        else if (request.opcode == OP_ADD_U32 || request.opcode == OP_MUL_U32)
        begin
            a1_next = {{HalfW{1'b0}}, request.operand_a[HalfW-1:0]};
            b1_next = {{HalfW{1'b0}}, request.operand_b[HalfW-1:0]};
        end
    end

    // add / subtract
    always_comb
    begin
        logic [DataW:0] sum;
        logic [DataW:0] dif;
        sum = {1'b0, a1_reg} + {1'b0, b1_reg};
        dif = {1'b0, a1_reg} - {1'b0, b1_reg};
        res2_next = '0;
        ovf2_next = 1'b0;
        unique case (op1_reg)
            OP_ADD_S32:
            begin
                res2_next = {{HalfW{sum[HalfW-1]}}, sum[HalfW-1:0]};
                ovf2_next = sum[DataW-1:HalfW-1] != {(HalfW+1){sum[HalfW-1]}};
            end
            OP_ADD_U32:
            begin
                res2_next = {{HalfW{1'b0}}, sum[HalfW-1:0]};
                ovf2_next = sum[HalfW];
            end
            OP_ADD_S64:
            begin
                res2_next = sum[DataW-1:0];
                ovf2_next = (a1_reg[DataW-1] == b1_reg[DataW-1]) &&
                            (a1_reg[DataW-1] != sum[DataW-1]);
            end
            OP_ADD_U64:
            begin
                res2_next = sum[DataW-1:0];
                ovf2_next = sum[DataW];
            end
            OP_SUB_S32:
            begin
                res2_next = {{HalfW{dif[HalfW-1]}}, dif[HalfW-1:0]};
                ovf2_next = dif[DataW-1:HalfW-1] != {(HalfW+1){dif[HalfW-1]}};
            end
            OP_SUB_S64:
            begin
                res2_next = dif[DataW-1:0];
                ovf2_next = (a1_reg[DataW-1] != b1_reg[DataW-1]) &&
                            (a1_reg[DataW-1] != dif[DataW-1]);
            end
            default:
            begin
                res2_next = '0;
                ovf2_next = 1'b0;
            end
        endcase
    end

    ocia_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (a1_reg),
        .b    (b1_reg),
        .prod (prod),
        .corr (corr)
    );

    // final select and multiply overflow
    always_comb
    begin
        data_t lo;
        data_t hi_u;
        data_t hi_s;
        lo   = prod[DataW-1:0];
        hi_u = prod[2*DataW-1:DataW];
        hi_s = hi_u - corr;
        res_o_next = res4_reg;
        ovf_o_next = ovf4_reg;
        unique case (op4_reg)
            OP_MUL_S32:
            begin
                res_o_next = {{HalfW{lo[HalfW-1]}}, lo[HalfW-1:0]};
                ovf_o_next = lo[DataW-1:HalfW] != {HalfW{lo[HalfW-1]}};
            end
            OP_MUL_U32:
            begin
                res_o_next = {{HalfW{1'b0}}, lo[HalfW-1:0]};
                ovf_o_next = lo[DataW-1:HalfW] != '0;
            end
            OP_MUL_S64:
            begin
                res_o_next = lo;
                ovf_o_next = hi_s != {DataW{lo[DataW-1]}};
            end
            OP_MUL_U64:
            begin
                res_o_next = lo;
                ovf_o_next = hi_u != '0;
            end
            default:
            begin
                res_o_next = res4_reg;
                ovf_o_next = ovf4_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= request.valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ldo) vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            op1_reg <= request.opcode;
            a1_reg  <= a1_next;
            b1_reg  <= b1_next;
        end
        if (ld2)
        begin
            op2_reg  <= op1_reg;
            res2_reg <= res2_next;
            ovf2_reg <= ovf2_next;
        end
        if (ld3)
        begin
            op3_reg  <= op2_reg;
            res3_reg <= res2_reg;
            ovf3_reg <= ovf2_reg;
        end
        if (ld4)
        begin
            op4_reg  <= op3_reg;
            res4_reg <= res3_reg;
            ovf4_reg <= ovf3_reg;
        end
        if (ldo)
        begin
            res_o_reg <= res_o_next;
            ovf_o_reg <= ovf_o_next;
        end
    end

    assign response.valid        = vo_reg;
    assign response.result_value = res_o_reg;
    assign response.overflowed   = ovf_o_reg;

endmodule
